>>> rtl/aqvc_pkg.sv
// shared constants for the air quality vent controller
`default_nettype none
package aqvc_pkg;

  // item kinds
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_BUTTON = 2'd2;
  localparam logic [1:0] OP_PHONE  = 2'd3;

  // actuator commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_RETRACT = 2'd2;
  localparam logic [1:0] CMD_STOP    = 2'd3;

  // actuator modes
  localparam logic [1:0] MODE_STOP_ADV = 2'd0;
  localparam logic [1:0] MODE_ADV      = 2'd1;
  localparam logic [1:0] MODE_STOP_RET = 2'd2;
  localparam logic [1:0] MODE_RET      = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COOLDOWN  = 2'd1;
  localparam logic [1:0] CFG_FLOOR     = 2'd2;

  localparam logic [6:0]  THRESHOLD_RST = 7'd50;
  localparam logic [7:0]  COOLDOWN_RST  = 8'd10;
  localparam logic [31:0] FLOOR_RST     = 32'd50000;

  // score arithmetic, fixed point form of 0.75 * gas + 0.25 * humidity
  localparam logic [16:0] HUM_LO   = 17'd38000;
  localparam logic [16:0] HUM_HI   = 17'd42000;
  localparam logic [16:0] HUM_SPAN = 17'd40000;
  localparam logic [16:0] GAS_K    = 17'd120000;
  localparam logic [16:0] DEN_K    = 17'd1600;
  localparam logic [6:0]  SCORE_NONE = 7'd50;
  localparam logic [6:0]  SCORE_MAX  = 7'd100;
  localparam int unsigned Q_BITS = 7;

  // phone digits
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] PB_ADVANCE = 8'd1;
  localparam logic [7:0] PB_RETRACT = 8'd2;
  localparam logic [7:0] PB_STOP    = 8'd3;

endpackage
`default_nettype wire

>>> rtl/aqvc_score.sv
// score unit: shared multiplier for the products, then restoring divide
`default_nettype none
module aqvc_score #(
  parameter int GAS_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [GAS_BITS-1:0] gas,
  input  wire logic [GAS_BITS-1:0] peak,
  input  wire logic [16:0]         humidity,
  output logic                     done,
  output logic [6:0]               score
);

  localparam int NUM_W  = GAS_BITS + 18;
  localparam int PROD_W = GAS_BITS + 17;
  localparam int DEN_W  = GAS_BITS + 11;
  localparam int Q_BITS_L = aqvc_pkg::Q_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]          st;
  logic [1:0]          step;
  logic [2:0]          bitpos;
  logic [GAS_BITS-1:0] m_r;
  logic [GAS_BITS-1:0] peak_r;
  logic [16:0]         hum_r;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    rem;
  logic [DEN_W-1:0]    den;
  logic [Q_BITS_L-1:0] quo;

  logic [16:0]         hum_dist;
  logic [16:0]         hum_part;
  logic [16:0]         mul_a;
  logic [GAS_BITS-1:0] mul_b;
  logic [NUM_W-1:0]    den_sh;
  logic                fits;

  // distance outside the comfort band and its humidity credit
  always_comb begin
    if (humidity < aqvc_pkg::HUM_LO) begin
      hum_dist = aqvc_pkg::HUM_LO - humidity;
    end else if (humidity > aqvc_pkg::HUM_HI) begin
      hum_dist = humidity - aqvc_pkg::HUM_HI;
    end else begin
      hum_dist = '0;
    end
    hum_part = (hum_dist < aqvc_pkg::HUM_SPAN) ? aqvc_pkg::HUM_SPAN - hum_dist : '0;
  end

  // operand select for the one multiplier
  always_comb begin
    case (step)
      2'd0:    mul_a = aqvc_pkg::GAS_K;
      2'd1:    mul_a = hum_r;
      default: mul_a = aqvc_pkg::DEN_K;
    endcase
    mul_b = (step == 2'd0) ? m_r : peak_r;
  end

  assign den_sh = NUM_W'(den) << bitpos;
  assign fits   = rem >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            st <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == 2'd3) begin
            st <= S_DIV;
          end
        end
        S_DIV: begin
          if (bitpos == 3'd0) begin
            st   <= S_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_IDLE && start) begin
      m_r    <= (gas < peak) ? gas : peak;
      peak_r <= peak;
      hum_r  <= hum_part;
      step   <= 2'd0;
    end
    if (st == S_MUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      step <= step + 2'd1;
      case (step)
        2'd1:    rem <= NUM_W'(prod);
        2'd2:    rem <= rem + NUM_W'(prod);
        2'd3: begin
          den    <= prod[DEN_W-1:0];
          bitpos <= 3'(Q_BITS_L - 1);
          quo    <= '0;
        end
        default: ;
      endcase
    end
    if (st == S_DIV) begin
      if (fits) begin
        rem         <= rem - den_sh;
        quo[bitpos] <= 1'b1;
      end
      bitpos <= bitpos - 3'd1;
    end
  end

  assign score = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> st == S_IDLE) else $error("score request while unit busy");
  a_done_range: assert property (@(posedge clk) disable iff (rst)
    done |-> score <= aqvc_pkg::SCORE_MAX) else $error("score above 100");
  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st) == S_DIV) else $error("done without divide");

endmodule
`default_nettype wire

>>> rtl/air_quality_vent_controller.sv
// air quality vent controller top level: mode, cooldown, baseline and result register
//
//  channel | direction | handshake            | contents
//  in      | request   | in_valid / in_ready  | opcode, gas_ohms, humidity_milli, phone_byte,
//          |           |                      | actuator_ready
//  out     | result    | out_valid / out_ready| cmd_valid, cmd_code, score_valid, air_score,
//          |           |                      | auto_alert, unknown_cmd, mode_now
//  cfg     | write     | cfg_we               | cfg_index, cfg_data
//
// tick, button, phone and no-baseline sample requests finish in the accept cycle; result next cycle
// a sample with a baseline goes through the three products on the shared multiplier,
// then 7 restoring divide steps for the score, then the result register load
// in_ready is low while a score is in the unit or a result waits with out_ready low
// synchronous reset restores the configuration registers, clears mode, cooldown, gas baseline and out_valid
`default_nettype none
module air_quality_vent_controller #(
  parameter int GAS_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] gas_ohms,
  input  wire logic [16:0] humidity_milli,
  input  wire logic [7:0]  phone_byte,
  input  wire logic        actuator_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             cmd_valid,
  output logic [1:0]       cmd_code,
  output logic             score_valid,
  output logic [6:0]       air_score,
  output logic             auto_alert,
  output logic             unknown_cmd,
  output logic [1:0]       mode_now,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SCORE = 1'b1;

  logic                st;
  logic [6:0]          threshold;
  logic [7:0]          cool_reload;
  logic [31:0]         base_floor;
  logic [1:0]          mode;
  logic [1:0]          mode_next;
  logic [7:0]          cooldown;
  logic [7:0]          cooldown_next;
  logic [GAS_BITS-1:0] gas_peak;
  logic [GAS_BITS-1:0] gas_peak_next;
  logic                rdy_r;

  logic                in_acc;
  logic                out_acc;
  logic                is_sample;
  logic [GAS_BITS-1:0] gas_in;
  logic                sc_start;
  logic                sc_done;
  logic [6:0]          sc_score;
  logic                fin;
  logic [6:0]          fin_score;
  logic                link_ok;
  logic                auto_go;
  logic [7:0]          pb;
  logic [1:0]          cmd;
  logic                unk;
  logic                load_out;

  assign in_ready  = (st == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign is_sample = opcode == aqvc_pkg::OP_SAMPLE;
  assign gas_in    = gas_ohms[GAS_BITS-1:0];

  // baseline rises only above the current peak and the floor
  assign gas_peak_next = (gas_in > gas_peak && 32'(gas_in) > base_floor) ? gas_in : gas_peak;

  assign sc_start  = in_acc && is_sample && gas_peak_next != '0;
  assign fin       = (in_acc && is_sample && gas_peak_next == '0) || sc_done;
  assign fin_score = sc_done ? sc_score : aqvc_pkg::SCORE_NONE;
  assign link_ok   = sc_done ? rdy_r : actuator_ready;
  assign auto_go   = fin_score < threshold && cooldown == 8'd0 && mode != aqvc_pkg::MODE_ADV;
  assign load_out  = (in_acc && !is_sample) || fin;

  // ascii digits fold to their value
  assign pb = (phone_byte >= aqvc_pkg::CHAR_0 && phone_byte <= aqvc_pkg::CHAR_9) ?
              phone_byte - aqvc_pkg::CHAR_0 : phone_byte;

  always_comb begin
    mode_next     = mode;
    cooldown_next = cooldown;
    cmd           = aqvc_pkg::CMD_NONE;
    unk           = 1'b0;
    if (in_acc) begin
      case (opcode)
        aqvc_pkg::OP_TICK: begin
          if (cooldown != 8'd0) begin
            cooldown_next = cooldown - 8'd1;
          end
        end
        aqvc_pkg::OP_BUTTON: begin
          cooldown_next = cool_reload;
          case (mode)
            aqvc_pkg::MODE_STOP_ADV: begin
              mode_next = aqvc_pkg::MODE_ADV;
              cmd       = aqvc_pkg::CMD_ADVANCE;
            end
            aqvc_pkg::MODE_ADV: begin
              mode_next = aqvc_pkg::MODE_STOP_RET;
              cmd       = aqvc_pkg::CMD_STOP;
            end
            aqvc_pkg::MODE_STOP_RET: begin
              mode_next = aqvc_pkg::MODE_RET;
              cmd       = aqvc_pkg::CMD_RETRACT;
            end
            default: begin
              mode_next = aqvc_pkg::MODE_STOP_ADV;
              cmd       = aqvc_pkg::CMD_STOP;
            end
          endcase
        end
        aqvc_pkg::OP_PHONE: begin
          cooldown_next = cool_reload;
          if (pb == aqvc_pkg::PB_ADVANCE) begin
            mode_next = aqvc_pkg::MODE_ADV;
            cmd       = aqvc_pkg::CMD_ADVANCE;
          end else if (pb == aqvc_pkg::PB_RETRACT) begin
            mode_next = aqvc_pkg::MODE_RET;
            cmd       = aqvc_pkg::CMD_RETRACT;
          end else if (pb == aqvc_pkg::PB_STOP) begin
            mode_next = aqvc_pkg::MODE_STOP_ADV;
            cmd       = aqvc_pkg::CMD_STOP;
          end else begin
            unk = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (fin && auto_go) begin
      mode_next = aqvc_pkg::MODE_ADV;
      cmd       = aqvc_pkg::CMD_ADVANCE;
    end
    if (!(fin ? link_ok : actuator_ready)) begin
      cmd = aqvc_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      threshold   <= aqvc_pkg::THRESHOLD_RST;
      cool_reload <= aqvc_pkg::COOLDOWN_RST;
      base_floor  <= aqvc_pkg::FLOOR_RST;
      mode        <= aqvc_pkg::MODE_STOP_ADV;
      cooldown    <= 8'd0;
      gas_peak    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aqvc_pkg::CFG_THRESHOLD: threshold   <= cfg_data[6:0];
          aqvc_pkg::CFG_COOLDOWN:  cool_reload <= cfg_data[7:0];
          aqvc_pkg::CFG_FLOOR:     base_floor  <= cfg_data;
          default: ;
        endcase
      end
      mode     <= mode_next;
      cooldown <= cooldown_next;
      if (in_acc && is_sample) begin
        gas_peak <= gas_peak_next;
      end
      if (sc_start) begin
        st <= ST_SCORE;
      end else if (sc_done) begin
        st <= ST_IDLE;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sc_start) begin
      rdy_r <= actuator_ready;
    end
    if (load_out) begin
      cmd_valid   <= cmd != aqvc_pkg::CMD_NONE;
      cmd_code    <= cmd;
      score_valid <= fin;
      air_score   <= fin ? fin_score : 7'd0;
      auto_alert  <= fin && auto_go;
      unknown_cmd <= unk;
      mode_now    <= mode_next;
    end
  end

  aqvc_score #(
    .GAS_BITS(GAS_BITS)
  ) u_score (
    .clk      (clk),
    .rst      (rst),
    .start    (sc_start),
    .gas      (gas_in),
    .peak     (gas_peak_next),
    .humidity (humidity_milli),
    .done     (sc_done),
    .score    (sc_score)
  );

  a_no_result_while_scoring: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCORE |-> !out_valid) else $error("result pending during score");
  a_done_only_scoring: assert property (@(posedge clk) disable iff (rst)
    sc_done |-> st == ST_SCORE) else $error("score done while idle");
  a_alert_is_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && auto_alert |-> score_valid && mode_now == aqvc_pkg::MODE_ADV)
    else $error("auto alert without advance on a sample");
  a_cmd_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cmd_valid == (cmd_code != aqvc_pkg::CMD_NONE))
    else $error("command valid and code disagree");

endmodule
`default_nettype wire
